/* src/limit_order_book_assert.svh */
// Assertion macros used by the checker file of the limit order book.
// Depends on nothing; each file that asserts includes this header.
`ifndef LIMIT_ORDER_BOOK_ASSERT_SVH
`define LIMIT_ORDER_BOOK_ASSERT_SVH
`define LOB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("limit order book check failed");
`define LOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("limit order book check failed");
`endif

/* src/lob_pkg.sv */
// Package of the limit order book: operation and status codes, cell types.
// Depends on nothing.
package lob_pkg;
  localparam int unsigned OrdersPerSideDef = 64;
  localparam int unsigned PriceW = 32;
  localparam int unsigned IdentW = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_REMOVE = 2'd1, OP_SET_LAST = 2'd2, OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_RSVD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE, FSM_WORK, FSM_OUT
  } fsm_e;

  // One entry of a side as it moves between cells.
  typedef struct packed {
    logic              used;
    logic [PriceW-1:0] price;
    logic [IdentW-1:0] ident;
  } entry_t;

  // Command broadcast to every cell of one side.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              clr;
    logic              is_sell;
    logic [PriceW-1:0] price;
    logic [IdentW-1:0] ident;
  } cmd_t;
endpackage

/* src/limit_order_book.sv */
// Limit order book with price-time priority built from two chains of cells.
// Depends on lob_pkg and lob_side.
//
// Input channel (valid/ready) carries op, side, price_ticks and order_ident.
// The output channel returns one result per input transfer: status, best bid,
// best ask and last traded price.
// An add, set-last or clear goes from the input transfer to the work state,
// in which an add shifts or loads the cells of its side and a clear empties
// both sides, and then to the output state, in which the result is shown.
// A remove stays in the work state while its side holds a match, since each
// shared compaction step takes out the first remaining match of the side.
// Only one item is in flight; ready is low until its result has been taken and
// rises in the following cycle, so no new item is taken before that result.
// While the receiver stalls, the result register holds its value.
// Reset empties both sides and sets the last price to zero; there is no
// clearing pass, as each cell carries its own used bit.
module limit_order_book #(
  parameter int unsigned ORDERS_PER_SIDE = lob_pkg::OrdersPerSideDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic        side_i,
  input  logic [31:0] price_ticks_i,
  input  logic [31:0] order_ident_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        bid_valid_o,
  output logic [31:0] bid_price_o,
  output logic [31:0] bid_order_o,
  output logic        ask_valid_o,
  output logic [31:0] ask_price_o,
  output logic [31:0] ask_order_o,
  output logic [31:0] last_price_o
);
  import lob_pkg::*;

  fsm_e    state_q, state_d;
  op_e     op_q;
  logic    sell_q;
  logic [31:0] price_q, ident_q, last_q, last_d;
  status_e status_q, status_d;
  logic    found_q, found_d;
  cmd_t    bcmd, acmd;
  entry_t  bbest, abest;
  logic    bfull, afull, bmat, amat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      last_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_e'(op_i);
      sell_q  <= side_i;
      price_q <= price_ticks_i;
      ident_q <= order_ident_i;
    end
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    found_d  = found_q;
    status_d = status_q;
    bcmd = '{ins: 1'b0, rem: 1'b0, clr: 1'b0, is_sell: 1'b0,
             price: price_q, ident: ident_q};
    acmd = '{ins: 1'b0, rem: 1'b0, clr: 1'b0, is_sell: 1'b1,
             price: price_q, ident: ident_q};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        found_d = 1'b0;
        if (in_valid_i) state_d = FSM_WORK;
      end
      FSM_WORK: begin
        unique case (op_q)
          OP_ADD: begin
            if (sell_q ? afull : bfull) status_d = ST_FULL;
            else begin
              status_d = ST_DONE;
              if (sell_q) acmd.ins = 1'b1;
              else bcmd.ins = 1'b1;
            end
            state_d = FSM_OUT;
          end
          OP_REMOVE: begin
            if (sell_q ? amat : bmat) begin
              found_d = 1'b1;
              if (sell_q) acmd.rem = 1'b1;
              else bcmd.rem = 1'b1;
            end else begin
              status_d = found_q ? ST_DONE : ST_NOT_FOUND;
              state_d = FSM_OUT;
            end
          end
          OP_SET_LAST: begin
            last_d = price_q;
            status_d = ST_DONE;
            state_d = FSM_OUT;
          end
          default: begin
            bcmd.clr = 1'b1;
            acmd.clr = 1'b1;
            last_d = '0;
            status_d = ST_DONE;
            state_d = FSM_OUT;
          end
        endcase
      end
      FSM_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  lob_side #(.Depth(ORDERS_PER_SIDE)) u_bid (
    .clk_i, .rst_ni, .cmd_i(bcmd), .best_o(bbest), .full_o(bfull), .any_match_o(bmat)
  );
  lob_side #(.Depth(ORDERS_PER_SIDE)) u_ask (
    .clk_i, .rst_ni, .cmd_i(acmd), .best_o(abest), .full_o(afull), .any_match_o(amat)
  );

  assign status_o     = status_q;
  assign bid_valid_o  = bbest.used;
  assign bid_price_o  = bbest.used ? bbest.price : '0;
  assign bid_order_o  = bbest.used ? bbest.ident : '0;
  assign ask_valid_o  = abest.used;
  assign ask_price_o  = abest.used ? abest.price : '0;
  assign ask_order_o  = abest.used ? abest.ident : '0;
  assign last_price_o = last_q;
endmodule

/* src/lob_cell.sv */
// One cell of a sorted side: holds one entry and shifts towards its neighbours.
// Depends on lob_pkg.
module lob_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lob_pkg::cmd_t   cmd_i,
  input  lob_pkg::entry_t left_i,
  input  logic            left_goes_after_i,
  input  lob_pkg::entry_t right_i,
  input  logic            right_match_i,
  output lob_pkg::entry_t entry_o,
  output logic            goes_after_o,
  output logic            match_o
);
  import lob_pkg::*;

  entry_t            entry_q, entry_d;
  logic              used_q;
  logic [PriceW-1:0] price_q;
  logic [IdentW-1:0] ident_q;
  logic              after;

  assign entry_q = '{used: used_q, price: price_q, ident: ident_q};

  // The new order goes before this entry when this entry is strictly worse.
  assign after = entry_q.used &&
                 (cmd_i.is_sell ? (entry_q.price > cmd_i.price)
                                : (entry_q.price < cmd_i.price));
  assign goes_after_o = after || !entry_q.used;
  assign match_o = entry_q.used && entry_q.price == cmd_i.price &&
                   entry_q.ident == cmd_i.ident;
  assign entry_o = entry_q;

  // Removal compacts one place per step; the side iterates until no match rests.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.clr) begin
      entry_d.used = 1'b0;
    end else if (cmd_i.ins) begin
      if (goes_after_o) begin
        if (left_goes_after_i) entry_d = left_i;
        else entry_d = '{used: 1'b1, price: cmd_i.price, ident: cmd_i.ident};
      end
    end else if (cmd_i.rem) begin
      if (match_o || right_match_i) entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= entry_d.used;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= entry_d.price;
    ident_q <= entry_d.ident;
  end
endmodule

/* src/lob_side.sv */
// One side of the book: a chain of cells kept sorted and compacted.
// Depends on lob_pkg and lob_cell.
module lob_side #(
  parameter int unsigned Depth = lob_pkg::OrdersPerSideDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lob_pkg::cmd_t   cmd_i,
  output lob_pkg::entry_t best_o,
  output logic            full_o,
  output logic            any_match_o
);
  import lob_pkg::*;

  entry_t     ent [Depth];
  logic [Depth-1:0] aft;
  logic [Depth-1:0] mat;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    entry_t lft, rgt;
    logic   lft_aft, rgt_mat;
    if (g == 0) begin : g_first
      assign lft = '0;
      assign lft_aft = 1'b0;
    end else begin : g_mid
      assign lft = ent[g-1];
      assign lft_aft = aft[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign rgt = '0;
      assign rgt_mat = 1'b0;
    end else begin : g_inner
      assign rgt = ent[g+1];
      assign rgt_mat = 1'b0;
    end
    // A cell shifts left only where the matching cell lies at or before it.
    logic prior_mat;
    if (g == 0) begin : g_pm0
      assign prior_mat = 1'b0;
    end else begin : g_pmn
      assign prior_mat = |mat[g-1:0];
    end
    lob_cell u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .left_i(lft), .left_goes_after_i(lft_aft),
      .right_i(rgt), .right_match_i(prior_mat | rgt_mat),
      .entry_o(ent[g]), .goes_after_o(aft[g]), .match_o(mat[g])
    );
  end

  assign best_o = ent[0];
  assign full_o = ent[Depth-1].used;
  assign any_match_o = |mat;
endmodule

/* src/lob_checker.sv */
// Port-level checks of the limit order book, bound to the top level.
// Depends on lob_pkg and limit_order_book_assert.svh.
`include "limit_order_book_assert.svh"
module lob_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        bid_valid_o,
  input logic [31:0] bid_price_o,
  input logic        ask_valid_o,
  input logic [31:0] ask_order_o
);
  import lob_pkg::*;

  `LOB_ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `LOB_ASSERT_IMPL(a_status, clk_i, rst_ni, out_valid_o, status_o != ST_RSVD)
  `LOB_ASSERT_IMPL(a_bid_zero, clk_i, rst_ni, !bid_valid_o, bid_price_o == '0)
  `LOB_ASSERT_IMPL(a_ask_zero, clk_i, rst_ni, !ask_valid_o, ask_order_o == '0)
  `LOB_ASSERT_NEXT(a_no_reaccept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind limit_order_book lob_checker u_lob_checker (.*);

/* bench/limit_order_book_test.sv */
// Self-checking testbench of the limit order book: adds, removes, last-price
// updates and clears are driven with random idling and checked against a model.
// Depends on lob_pkg and limit_order_book.
module limit_order_book_test;
  import lob_pkg::*;

  localparam int unsigned Depth = OrdersPerSideDef;

  typedef struct packed {
    op_e         op;
    logic        side;
    logic [31:0] price;
    logic [31:0] ident;
  } event_t;

  typedef struct packed {
    status_e     status;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [31:0] bid_order;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] ask_order;
    logic [31:0] last_price;
  } quote_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = '0;
  logic        side_i = 1'b0;
  logic [31:0] price_ticks_i = '0;
  logic [31:0] order_ident_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        bid_valid_o;
  logic [31:0] bid_price_o;
  logic [31:0] bid_order_o;
  logic        ask_valid_o;
  logic [31:0] ask_price_o;
  logic [31:0] ask_order_o;
  logic [31:0] last_price_o;

  limit_order_book dut (.*);

  always #5 clk_i = ~clk_i;

  event_t      pending_events[$];
  quote_t      expected_quotes[$];
  logic [31:0] bid_px[$];
  logic [31:0] bid_id[$];
  logic [31:0] ask_px[$];
  logic [31:0] ask_id[$];
  logic [31:0] traded;
  int          errors;
  int          accepted;
  int          calm_from;
  int          calm_to;
  logic        in_taken = 1'b0;
  logic [31:0] recent_px[$];
  logic [31:0] recent_id[$];

  function automatic quote_t apply_event(event_t e);
    quote_t q;
    int     n;
    int     pos;
    logic   hit;
    q = '0;
    q.status = ST_DONE;
    case (e.op)
      OP_ADD: begin
        n = e.side ? ask_px.size() : bid_px.size();
        if (n >= Depth) begin
          q.status = ST_FULL;
        end else begin
          pos = n;
          for (int i = n - 1; i >= 0; i--) begin
            if (e.side ? (ask_px[i] > e.price) : (bid_px[i] < e.price)) pos = i;
          end
          if (e.side) begin
            ask_px.insert(pos, e.price);
            ask_id.insert(pos, e.ident);
          end else begin
            bid_px.insert(pos, e.price);
            bid_id.insert(pos, e.ident);
          end
        end
      end
      OP_REMOVE: begin
        hit = 1'b0;
        if (e.side) begin
          for (int i = ask_px.size() - 1; i >= 0; i--) begin
            if (ask_px[i] == e.price && ask_id[i] == e.ident) begin
              ask_px.delete(i);
              ask_id.delete(i);
              hit = 1'b1;
            end
          end
        end else begin
          for (int i = bid_px.size() - 1; i >= 0; i--) begin
            if (bid_px[i] == e.price && bid_id[i] == e.ident) begin
              bid_px.delete(i);
              bid_id.delete(i);
              hit = 1'b1;
            end
          end
        end
        if (!hit) q.status = ST_NOT_FOUND;
      end
      OP_SET_LAST: traded = e.price;
      default: begin
        bid_px.delete();
        bid_id.delete();
        ask_px.delete();
        ask_id.delete();
        traded = '0;
      end
    endcase
    if (bid_px.size() > 0) begin
      q.bid_valid = 1'b1;
      q.bid_price = bid_px[0];
      q.bid_order = bid_id[0];
    end
    if (ask_px.size() > 0) begin
      q.ask_valid = 1'b1;
      q.ask_price = ask_px[0];
      q.ask_order = ask_id[0];
    end
    q.last_price = traded;
    return q;
  endfunction

  task automatic push_event(op_e op, logic side, logic [31:0] price, logic [31:0] ident);
    event_t e;
    e.op = op;
    e.side = side;
    e.price = price;
    e.ident = ident;
    pending_events = {pending_events, e};
  endtask

  function automatic logic idle_now();
    return !(accepted >= calm_from && accepted < calm_to) && ($urandom_range(99) < 24);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (pending_events.size() > 0 && !idle_now()) begin
          in_valid_i <= 1'b1;
          op_i <= pending_events[0].op;
          side_i <= pending_events[0].side;
          price_ticks_i <= pending_events[0].price;
          order_ident_i <= pending_events[0].ident;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !idle_now();
    end
  end

  always @(posedge clk_i) begin
    quote_t got;
    quote_t exp;
    if (rst_ni && in_valid_i && in_ready_o) begin
      exp = apply_event(pending_events[0]);
      expected_quotes = {expected_quotes, exp};
      void'(pending_events.pop_front());
      in_taken = 1'b1;
      accepted <= accepted + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_e'(status_o), bid_valid_o, bid_price_o, bid_order_o,
             ask_valid_o, ask_price_o, ask_order_o, last_price_o};
      if (expected_quotes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = expected_quotes.pop_front();
        if (got !== exp) begin
          $display("%0t: expected %h actual %h", $time, exp, got);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_price();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + 32'($urandom_range(15));
      default: return 32'(1000 + $urandom_range(20));
    endcase
  endfunction

  initial begin
    int r;
    int k;
    logic [31:0] p;
    logic [31:0] id;
    errors = 0;
    accepted = 0;
    traded = '0;
    calm_from = 400;
    calm_to = 550;
    // Directed: extremes, duplicates, ties, misses, and filling one side.
    push_event(OP_ADD, 1'b0, 32'h0, 32'h0);
    push_event(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'h1);
    push_event(OP_ADD, 1'b1, 32'h0, 32'h2);
    push_event(OP_ADD, 1'b1, 32'h0, 32'h3);
    push_event(OP_ADD, 1'b1, 32'h0, 32'h2);
    push_event(OP_REMOVE, 1'b1, 32'h0, 32'h2);
    push_event(OP_REMOVE, 1'b1, 32'h0, 32'h2);
    push_event(OP_REMOVE, 1'b0, 32'h5, 32'h0);
    push_event(OP_SET_LAST, 1'b1, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    push_event(OP_CLEAR, 1'b0, 32'h1234, 32'h5678);
    push_event(OP_REMOVE, 1'b1, 32'h0, 32'h3);
    for (int i = 0; i < Depth + 2; i++) push_event(OP_ADD, 1'b0, 32'(i % 7), 32'(i));
    push_event(OP_CLEAR, 1'b1, 32'h0, 32'h0);
    // Random: mostly adds and removes of recently added orders, some noise.
    for (int i = 0; i < 1300; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        p = rand_price();
        id = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(40));
        push_event(OP_ADD, 1'($urandom_range(1)), p, id);
        recent_px = {recent_px, p};
        recent_id = {recent_id, id};
        if (recent_px.size() > 200) begin
          void'(recent_px.pop_front());
          void'(recent_id.pop_front());
        end
      end else if (r < 80 && recent_px.size() > 0) begin
        k = $urandom_range(recent_px.size() - 1);
        push_event(OP_REMOVE, 1'($urandom_range(1)), recent_px[k], recent_id[k]);
      end else if (r < 88) begin
        push_event(OP_REMOVE, 1'($urandom_range(1)), $urandom(), $urandom());
      end else if (r < 97) begin
        push_event(OP_SET_LAST, 1'($urandom_range(1)), $urandom(), $urandom());
      end else begin
        push_event(OP_CLEAR, 1'($urandom_range(1)), $urandom(), $urandom());
      end
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_events.size() == 0 && expected_quotes.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_quotes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/lob_pkg.sv
src/lob_cell.sv
src/lob_side.sv
src/limit_order_book.sv
src/lob_checker.sv
bench/limit_order_book_test.sv
